FILE: rtl/ptts_pkg.sv
// Shared codes and types for the periodic task tick scheduler.
// No dependencies; imported by ptts_alu, ptts_ctrl, the top level and the testbench.
package ptts_pkg;

	// Request codes carried by req_type.
	localparam logic [1:0] REQ_CREATE   = 2'd0;
	localparam logic [1:0] REQ_OVERFLOW = 2'd1;
	localparam logic [1:0] REQ_START    = 2'd2;

	// Result codes carried by event_res.
	localparam logic [1:0] RES_DISPATCH = 2'd0;
	localparam logic [1:0] RES_CREATED  = 2'd1;
	localparam logic [1:0] RES_REJECTED = 2'd2;

	// Most dispatch results reported for one request.
	localparam int unsigned MAX_RESULTS = 8;

	// Output of the shared countdown unit.
	typedef struct packed {
		logic [7:0] next_cd;
		logic       ready;
	} alu_res_t;

endpackage

FILE: rtl/ptts_req_if.sv
// Request channel of the scheduler: valid/ready handshake and request payload.
// No dependencies.
interface ptts_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] first_delay;
	logic [7:0] period;

	modport source(output valid, output req_type, output first_delay, output period,
		input ready);
	modport sink(input valid, input req_type, input first_delay, input period,
		output ready);
endinterface

FILE: rtl/ptts_res_if.sv
// Result channel of the scheduler: valid/ready handshake and result payload.
// No dependencies.
interface ptts_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_res;
	logic [2:0] task_index;
	logic       last;

	modport source(output valid, output event_res, output task_index, output last,
		input ready);
	modport sink(input valid, input event_res, input task_index, input last,
		output ready);
endinterface

FILE: rtl/ptts_table.sv
// Task table memory: countdown and reload period per task, one write port and
// one registered read port. No package dependencies.
module ptts_table #(
	parameter int unsigned NUM_TASKS = 8,
	parameter int unsigned IW        = 3
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  logic [7:0]    wr_cd,
	input  logic [7:0]    wr_per,
	input  logic [IW-1:0] rd_addr,
	output logic [7:0]    rd_cd,
	output logic [7:0]    rd_per
);

	logic [7:0] cd_mem  [NUM_TASKS];
	logic [7:0] per_mem [NUM_TASKS];
	logic [7:0] rd_cd_q;
	logic [7:0] rd_per_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cd_mem[wr_addr]  <= wr_cd;
			per_mem[wr_addr] <= wr_per;
		end
		rd_cd_q  <= cd_mem[rd_addr];
		rd_per_q <= per_mem[rd_addr];
	end

	assign rd_cd  = rd_cd_q;
	assign rd_per = rd_per_q;

endmodule

FILE: rtl/ptts_alu.sv
// Shared countdown unit: decrement with reload on a tick, then test for one.
// Depends on ptts_pkg for the result struct.
module ptts_alu (
	input  logic              [7:0] cd,
	input  logic              [7:0] per,
	input  logic                    tick,
	output ptts_pkg::alu_res_t      res
);
	import ptts_pkg::*;

	logic [7:0] dec;
	logic [7:0] nxt;

	always_comb begin
		dec = cd - 8'd1;
		if (tick) begin
			nxt = (dec == 8'd0) ? per : dec;
		end else begin
			nxt = cd;
		end
		res.next_cd = nxt;
		res.ready   = (nxt == 8'd1);
	end

endmodule

FILE: rtl/ptts_ctrl.sv
// Sequencer of the scheduler: request decode, prescaler, table walk, pending
// result and output register. Depends on ptts_pkg and the two channel interfaces.
module ptts_ctrl #(
	parameter int unsigned NUM_TASKS = 8,
	parameter int unsigned IW        = 3,
	parameter int unsigned CW        = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic              [7:0] cfg_wdata,
	ptts_req_if.sink                req,
	ptts_res_if.source              res,
	output logic                    wr_en,
	output logic           [IW-1:0] wr_addr,
	output logic              [7:0] wr_cd,
	output logic              [7:0] wr_per,
	output logic           [IW-1:0] rd_addr,
	input  logic              [7:0] rd_per,
	output logic                    tick,
	input  ptts_pkg::alu_res_t      alu
);
	import ptts_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_WB, ST_FLUSH} state_t;

	state_t        state_q;
	logic [7:0]    thresh_q;
	logic [7:0]    prescale_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] addr_q;
	logic          tick_q;
	logic [3:0]    nres_q;
	logic          pend_v_q;
	logic [1:0]    pend_res_q;
	logic [2:0]    pend_idx_q;
	logic          out_v_q;
	logic [1:0]    out_res_q;
	logic [2:0]    out_idx_q;
	logic          out_last_q;

	logic       accept;
	logic       slot_free;
	logic       full;
	logic [7:0] presc_inc;
	logic       last_entry;
	logic       disp;
	logic       wb_stall;
	logic       push;
	logic       push_last;

	always_comb begin
		accept     = req.valid && (state_q == ST_IDLE);
		slot_free  = !out_v_q || res.ready;
		full       = (count_q == CW'(NUM_TASKS));
		presc_inc  = prescale_q + 8'd1;
		last_entry = ((CW'(addr_q) + CW'(1)) == count_q);
		disp       = alu.ready && (nres_q < 4'(MAX_RESULTS));
		wb_stall   = disp && pend_v_q && !slot_free;
		push       = 1'b0;
		push_last  = 1'b0;
		if (state_q == ST_WB && !wb_stall && disp && pend_v_q) begin
			push = 1'b1;
		end
		if (state_q == ST_FLUSH && slot_free) begin
			push      = 1'b1;
			push_last = 1'b1;
		end

		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_cd   = alu.next_cd;
		wr_per  = rd_per;
		if (accept && req.req_type == REQ_CREATE && !full) begin
			wr_en   = 1'b1;
			wr_addr = count_q[IW-1:0];
			wr_cd   = req.first_delay + 8'd1;
			wr_per  = req.period;
		end else if (state_q == ST_WB && !wb_stall && tick_q) begin
			wr_en = 1'b1;
		end
	end

	assign rd_addr        = addr_q;
	assign tick           = tick_q;
	assign req.ready      = (state_q == ST_IDLE);
	assign res.valid      = out_v_q;
	assign res.event_res  = out_res_q;
	assign res.task_index = out_idx_q;
	assign res.last       = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			thresh_q   <= 8'd0;
			prescale_q <= 8'd0;
			count_q    <= '0;
			addr_q     <= '0;
			tick_q     <= 1'b0;
			nres_q     <= 4'd0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				thresh_q <= cfg_wdata;
			end

			if (push) begin
				out_v_q    <= 1'b1;
				out_res_q  <= pend_res_q;
				out_idx_q  <= pend_idx_q;
				out_last_q <= push_last;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_CREATE: begin
								pend_v_q   <= 1'b1;
								pend_res_q <= full ? RES_REJECTED : RES_CREATED;
								pend_idx_q <= full ? 3'd0 : 3'(count_q);
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
								state_q <= ST_FLUSH;
							end
							REQ_OVERFLOW: begin
								if (presc_inc > thresh_q) begin
									prescale_q <= 8'd0;
									tick_q     <= 1'b1;
									addr_q     <= '0;
									nres_q     <= 4'd0;
									state_q    <= (count_q != '0) ? ST_RD : ST_IDLE;
								end else begin
									prescale_q <= presc_inc;
								end
							end
							REQ_START: begin
								tick_q  <= 1'b0;
								addr_q  <= '0;
								nres_q  <= 4'd0;
								state_q <= (count_q != '0) ? ST_RD : ST_IDLE;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (!wb_stall) begin
						if (disp) begin
							pend_v_q   <= 1'b1;
							pend_res_q <= RES_DISPATCH;
							pend_idx_q <= 3'(addr_q);
							nres_q     <= nres_q + 4'd1;
						end
						if (last_entry) begin
							state_q <= (pend_v_q || disp) ? ST_FLUSH : ST_IDLE;
						end else begin
							addr_q  <= addr_q + IW'(1);
							state_q <= ST_RD;
						end
					end
				end
				ST_FLUSH: begin
					if (slot_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A new request is taken only with no result left over from the last one.
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !pend_v_q)
		else $error("request taken while a result is still pending");

	// Leaving the flush state always puts a final result in the output register.
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && slot_free) |=> (out_v_q && out_last_q))
		else $error("flush did not deliver a final result");

	// The task count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(NUM_TASKS))
		else $error("task count beyond table depth");

	// The walk only visits entries that hold a task.
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_WB) |-> (CW'(addr_q) < count_q))
		else $error("walk address beyond task count");

endmodule

FILE: rtl/periodic_task_tick_scheduler.sv
// Periodic task tick scheduler, top level.
// Sequence: a create gives its result through the flush state; an overflow
// without a tick stays idle; a tick or start walks the table one task at a time
// (memory read, then update/write-back, which holds while a result is blocked),
// then flushes the last result when a dispatch is reported, or goes idle when
// none is. Requests: one at a time, set by that table walk; no clearing pass.
// Reset: arst_n clears control, prescaler, task count and threshold at once.
//
// Structure: a small sequencer (ptts_ctrl) walks the task table (ptts_table)
// through one shared countdown unit (ptts_alu). Each dispatch found during the
// walk is first held as a pending result, so that the one before it can be sent
// with last low; the final pending result goes out with last high. The output
// register lets a finished result wait for the sink while the walk goes on,
// and the walk holds still only when a second result would overrun it.
module periodic_task_tick_scheduler #(
	parameter int unsigned NUM_TASKS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	ptts_req_if.sink   in,
	ptts_res_if.source out
);
	import ptts_pkg::*;

	// Table address width and task count width (count must reach NUM_TASKS).
	localparam int unsigned IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int unsigned CW = $clog2(NUM_TASKS + 1);

	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [7:0]    wr_cd;
	logic [7:0]    wr_per;
	logic [IW-1:0] rd_addr;
	logic [7:0]    rd_cd;
	logic [7:0]    rd_per;
	logic          tick;
	alu_res_t      alu;

	// Task table: written by create requests and by tick write-backs.
	ptts_table #(
		.NUM_TASKS(NUM_TASKS),
		.IW       (IW)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_cd  (wr_cd),
		.wr_per (wr_per),
		.rd_addr(rd_addr),
		.rd_cd  (rd_cd),
		.rd_per (rd_per)
	);

	// Shared countdown unit, fed by the registered table read.
	ptts_alu u_alu (
		.cd  (rd_cd),
		.per (rd_per),
		.tick(tick),
		.res (alu)
	);

	// Sequencer with prescaler, threshold register and output register.
	ptts_ctrl #(
		.NUM_TASKS(NUM_TASKS),
		.IW       (IW),
		.CW       (CW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (in),
		.res      (out),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_cd    (wr_cd),
		.wr_per   (wr_per),
		.rd_addr  (rd_addr),
		.rd_per   (rd_per),
		.tick     (tick),
		.alu      (alu)
	);

endmodule

FILE: tb/ptts_dispatch_monitor.sv
`timescale 1ns / 1ps
// Dispatch monitor for the periodic task tick scheduler testbench.
// Depends on ptts_pkg and the ptts_req_if / ptts_res_if channel interfaces.
module ptts_dispatch_monitor #(
	parameter int unsigned NUM_TASKS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	ptts_req_if        req_ch,
	ptts_res_if        res_ch,
	output int         errors,
	output int         pending,
	output int         results_checked
);
	import ptts_pkg::*;

	typedef struct packed {
		logic [1:0] event_res;
		logic [2:0] task_index;
		logic       last;
	} sched_event_t;

	// Shadow copy of the scheduler state.
	logic [7:0] tick_threshold;
	logic [7:0] prescale;
	int         task_count;
	logic [7:0] cd_value [NUM_TASKS];
	logic [7:0] reload_value [NUM_TASKS];

	sched_event_t expected_events [$];

	task automatic report_mismatch(input string what);
		errors++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// Every task sitting at countdown 1 is dispatched, lowest index first, up to MAX_RESULTS.
	function automatic void queue_dispatches();
		int           n;
		int           k;
		sched_event_t ev;
		n = 0;
		for (int i = 0; i < task_count; i++) begin
			if (cd_value[i] == 8'd1 && n < MAX_RESULTS) begin
				n++;
			end
		end
		k = 0;
		for (int i = 0; i < task_count; i++) begin
			if (cd_value[i] == 8'd1 && k < n) begin
				k++;
				ev.event_res  = RES_DISPATCH;
				ev.task_index = 3'(i);
				ev.last       = (k == n);
				expected_events.push_back(ev);
			end
		end
	endfunction

	function automatic void schedule_request(input logic [1:0] kind, input logic [7:0] delay,
		input logic [7:0] per);
		sched_event_t ev;
		case (kind)
			REQ_CREATE: begin
				if (task_count < NUM_TASKS) begin
					cd_value[task_count]     = delay + 8'd1;
					reload_value[task_count] = per;
					ev.event_res  = RES_CREATED;
					ev.task_index = 3'(task_count);
					task_count++;
				end else begin
					ev.event_res  = RES_REJECTED;
					ev.task_index = 3'd0;
				end
				ev.last = 1'b1;
				expected_events.push_back(ev);
			end
			REQ_OVERFLOW: begin
				prescale = prescale + 8'd1;
				if (prescale > tick_threshold) begin
					for (int i = 0; i < task_count; i++) begin
						cd_value[i] = cd_value[i] - 8'd1;
						if (cd_value[i] == 8'd0) begin
							cd_value[i] = reload_value[i];
						end
					end
					prescale = 8'd0;
					queue_dispatches();
				end
			end
			REQ_START: begin
				queue_dispatches();
			end
			default: begin
			end
		endcase
	endfunction

	task automatic check_result();
		sched_event_t got;
		sched_event_t want;
		got = {res_ch.event_res, res_ch.task_index, res_ch.last};
		results_checked++;
		if (expected_events.size() == 0) begin
			report_mismatch($sformatf("unexpected result event %0d task %0d last %0d",
				got.event_res, got.task_index, got.last));
		end else begin
			want = expected_events.pop_front();
			if (got.event_res !== want.event_res || got.task_index !== want.task_index ||
				got.last !== want.last) begin
				report_mismatch($sformatf("event %0d task %0d last %0d, expected %0d/%0d/%0d",
					got.event_res, got.task_index, got.last,
					want.event_res, want.task_index, want.last));
			end
		end
	endtask

	// A result transfer is checked before a request transfer of the same edge
	// is predicted, since the block answers one request at a time.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_threshold = 8'd0;
			prescale       = 8'd0;
			task_count     = 0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				cd_value[i]     = 8'd0;
				reload_value[i] = 8'd0;
			end
			expected_events.delete();
			errors          = 0;
			results_checked = 0;
			pending         = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				check_result();
			end
			if (cfg_we) begin
				tick_threshold = cfg_wdata;
			end
			if (req_ch.valid && req_ch.ready) begin
				schedule_request(req_ch.req_type, req_ch.first_delay, req_ch.period);
			end
			pending = expected_events.size();
		end
	end

endmodule

FILE: tb/periodic_task_tick_scheduler_test.sv
`timescale 1ns / 1ps
// Top level of the periodic task tick scheduler testbench: clock, reset and stimulus.
// Depends on ptts_pkg, the channel interfaces, the block and ptts_dispatch_monitor.
module periodic_task_tick_scheduler_test;
	import ptts_pkg::*;

	localparam int unsigned NUM_TASKS = 8;
	// A tick walks the whole table, one read and one write-back step per task; this covers that
	// walk plus some margin whenever a request may leave no result behind.
	localparam int SETTLE_CYCLES = 2 * NUM_TASKS + 8;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 70;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	ptts_req_if req_ch();
	ptts_res_if res_ch();

	int errors;
	int pending;
	int results_checked;

	// When set, neither side inserts gaps or stalls.
	bit calm;

	int sent_create;
	int sent_overflow;
	int sent_start;
	int threshold_writes;

	periodic_task_tick_scheduler #(.NUM_TASKS(NUM_TASKS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in       (req_ch),
		.out      (res_ch)
	);

	// The monitor predicts every result from the observed transfers and
	// hands back its mismatch count and the number of results still owed.
	ptts_dispatch_monitor #(.NUM_TASKS(NUM_TASKS)) monitor_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.req_ch         (req_ch),
		.res_ch         (res_ch),
		.errors         (errors),
		.pending        (pending),
		.results_checked(results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs: several times the slowest legal run,
	// where every result waits out the longest receiver stall.
	initial begin
		#1_600_000;
		$display("Timeout: the run did not reach its end, %0d results still owed", pending);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Most gaps are zero or short; a few are long, so that pauses land on
	// every phase of the table walk.
	function automatic int gap_len();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Result side: after each cycle in which ready was high, it may drop for a
	// random gap drawn by gap_len.
	initial begin : result_sink
		int stall;
		stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				stall--;
			end else begin
				res_ch.ready <= 1'b1;
				stall = gap_len();
			end
		end
	end

	// Presents one request and returns at the falling edge after its
	// transfer, with valid still high so that back-to-back requests do not
	// drop it in between.
	task automatic send_req(input logic [1:0] kind, input logic [7:0] delay,
		input logic [7:0] per);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= kind;
		req_ch.first_delay <= delay;
		req_ch.period      <= per;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
		case (kind)
			REQ_CREATE:   sent_create++;
			REQ_OVERFLOW: sent_overflow++;
			REQ_START:    sent_start++;
			default: begin
			end
		endcase
	endtask

	// The threshold only changes while the block is idle: the sender stops,
	// every owed result is drained, and the block gets time to finish a walk
	// that produced nothing before the write.
	task automatic write_threshold(input logic [7:0] value);
		req_ch.valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		threshold_writes++;
	endtask

	// Random traffic is mostly overflows, which drive the ticks, with some
	// starts and a few creates that hit the full table.
	task automatic random_traffic(input int count);
		int         r;
		logic [1:0] kind;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				kind = REQ_OVERFLOW;
			end else if (r < 92) begin
				kind = REQ_START;
			end else begin
				kind = REQ_CREATE;
			end
			send_req(kind, 8'($urandom), 8'($urandom));
		end
	endtask

	initial begin : stimulus
		logic [7:0] threshold;
		req_ch.valid       = 1'b0;
		req_ch.req_type    = REQ_CREATE;
		req_ch.first_delay = 8'd0;
		req_ch.period      = 8'd0;
		res_ch.ready       = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = 8'd0;
		calm               = 1'b0;
		arst_n             = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, threshold 0 so that every overflow ticks.
		write_threshold(8'd0);
		// With an empty table, neither a start nor a tick reports anything.
		send_req(REQ_START, 8'd0, 8'd0);
		send_req(REQ_OVERFLOW, 8'd255, 8'd255);
		// Fill the table. A period of 1 dispatches on every tick; a first
		// delay of 255 starts the countdown at 0; a period of 0 reloads 0,
		// which the next tick wraps to 255.
		send_req(REQ_CREATE, 8'd0, 8'd1);
		send_req(REQ_CREATE, 8'd255, 8'd0);
		send_req(REQ_CREATE, 8'd1, 8'd2);
		send_req(REQ_CREATE, 8'd2, 8'd3);
		send_req(REQ_CREATE, 8'd254, 8'd255);
		send_req(REQ_CREATE, 8'd0, 8'd0);
		send_req(REQ_CREATE, 8'd3, 8'd5);
		send_req(REQ_CREATE, 8'd100, 8'd4);
		// The table is full from here on, so creates are rejected.
		send_req(REQ_CREATE, 8'd255, 8'd255);
		send_req(REQ_CREATE, 8'd0, 8'd0);
		// Start dispatches every task at countdown 1, then a few ticks.
		send_req(REQ_START, 8'd0, 8'd0);
		send_req(REQ_OVERFLOW, 8'd0, 8'd0);
		send_req(REQ_OVERFLOW, 8'd0, 8'd0);
		send_req(REQ_OVERFLOW, 8'd255, 8'd255);
		send_req(REQ_START, 8'd255, 8'd255);
		send_req(REQ_OVERFLOW, 8'd0, 8'd0);

		// Random phases, each with its own threshold. A threshold of 255
		// means the prescaler wraps first and ticks never happen, so only
		// starts report anything there. One phase runs without any idling.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: threshold = 8'd0;
				1: threshold = 8'd255;
				2: threshold = 8'd1;
				3: threshold = 8'd3;
				4: threshold = 8'($urandom_range(4, 12));
				default: threshold = 8'd2;
			endcase
			write_threshold(threshold);
			calm = (p == 2);
			random_traffic(ITEMS_PER_PHASE);
		end
		calm = 1'b0;

		// Drain what is still owed, with a bound, then let the block settle.
		req_ch.valid <= 1'b0;
		for (int w = 0; w < 20000 && pending != 0; w++) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Covered %0d requests (%0d create, %0d overflow, %0d start) over %0d thresholds.",
			sent_create + sent_overflow + sent_start, sent_create, sent_overflow, sent_start,
			threshold_writes);
		$display("Checked %0d results; thresholds included 0 and 255.", results_checked);
		if (pending != 0) begin
			$display("%0d expected results never arrived", pending);
		end
		if (errors == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
